// ----- sv/xcs_pkg.sv -----
// xcs_pkg: shared types and constants of the xor closest shortlist
// entry record, action codes, register indexes and field widths
// no dependencies
package xcs_pkg;

    localparam int DEF_LIST_SIZE = 16;

    localparam int ID_W        = 32;
    localparam int IP_W        = 32;
    localparam int PORT_W      = 16;
    localparam int ACTION_W    = 2;
    localparam int COUNT_OUT_W = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    // action codes of an input item
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TAKE   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CREATOR = 1'b1;

    // one contact as held in the entry memory
    typedef struct packed {
        logic [ID_W-1:0]   node;
        logic [IP_W-1:0]   address;
        logic [PORT_W-1:0] port;
        logic              queried;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- sv/xcs_ram.sv -----
// xcs_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module xcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- sv/xcs_qmark.sv -----
// xcs_qmark: flop mirror of the queried marks, one per list position
// finds the nearest unqueried held entry and reports whether any remains
// no dependencies
module xcs_qmark #(
    parameter int LIST_SIZE = 16,
    parameter int IDX_W     = 4,
    parameter int CNT_W     = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clr_all,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic             wr_val,
    input  logic [CNT_W-1:0] count,
    output logic             first_hit,
    output logic [IDX_W-1:0] first_idx,
    output logic             pending
);

    logic [LIST_SIZE-1:0] qmark_reg;
    logic [LIST_SIZE-1:0] qmark_next;
    logic [LIST_SIZE-1:0] live;

    always_comb begin
        qmark_next = qmark_reg;
        if (clr_all) begin
            qmark_next = '1;
        end else if (wr_en) begin
            qmark_next[wr_idx] = wr_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qmark_reg <= '1;
        end else begin
            qmark_reg <= qmark_next;
        end
    end

    // unqueried and below the held count
    always_comb begin
        first_idx = '0;
        for (int k = 0; k < LIST_SIZE; k++) begin
            live[k] = !qmark_reg[k] && (CNT_W'(k) < count);
        end
        for (int k = LIST_SIZE - 1; k >= 0; k--) begin
            if (live[k]) begin
                first_idx = IDX_W'(k);
            end
        end
        first_hit = |live;
        pending   = |live;
    end

endmodule

// ----- sv/xor_closest_shortlist_top.sv -----
// xor_closest_shortlist_top: shortlist of the closest contacts by xor distance
// depends on xcs_pkg, xcs_ram (entry memory) and xcs_qmark (queried marks)
//
// usage
//   input channel s_*: one item per handshake, s_action selects insert,
//   take-next or clear; s_node_id, s_address, s_port carry the candidate.
//   result channel m_*: exactly one item per input item, in order, with the
//   returned entry (found), the pending flag and the held count.
//   cfg_*: plain write port, index 0 target id, index 1 creator id; write
//   only while the block is idle.
// steps (one item at a time, one entry moved per cycle through the entry memory)
//   clear, unused action, take-next with nothing left: finish; other take: read, write back, finish
//   insert with room: walk the candidate down from the end unless the list is empty, place, finish
//   full list: scan every entry for the id, then finish if dropped, or walk and place if kept
//   first insert after a target write: adds a re-sort of the held entries,
//   a load, walk and place for each held entry past the first, before the insert itself
// reset clears the count, the marks and the control registers; the entry memory is
//   not cleared, only entries below the count are ever read
// a stalled result holds m_* and blocks only the finish step; an item can
//   be accepted and worked on while the previous result still waits
module xor_closest_shortlist_top
    import xcs_pkg::*;
#(
    parameter int LIST_SIZE = DEF_LIST_SIZE
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    // input items
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [ACTION_W-1:0]    s_action,
    input  logic [ID_W-1:0]        s_node_id,
    input  logic [IP_W-1:0]        s_address,
    input  logic [PORT_W-1:0]      s_port,
    // result items
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_found,
    output logic [ID_W-1:0]        m_out_node_id,
    output logic [IP_W-1:0]        m_out_address,
    output logic [PORT_W-1:0]      m_out_port,
    output logic                   m_pending,
    output logic [COUNT_OUT_W-1:0] m_count
);

    localparam int IDX_W  = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
    localparam int CNT_W  = $clog2(LIST_SIZE + 1);
    localparam int PENULT = (LIST_SIZE > 1) ? LIST_SIZE - 2 : 0;

    // sequencer states
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SORT_LOAD = 3'd1;  // fetch next entry of a full re-sort
    localparam logic [2:0] ST_DECIDE    = 3'd2;  // append or start the full-list scan
    localparam logic [2:0] ST_SCAN      = 3'd3;  // duplicate scan of a full list
    localparam logic [2:0] ST_WALK      = 3'd4;  // shift farther entries up by one
    localparam logic [2:0] ST_PLACE     = 3'd5;  // write the held entry at its slot
    localparam logic [2:0] ST_TAKE_WB   = 3'd6;  // write back the taken entry as queried
    localparam logic [2:0] ST_FINISH    = 3'd7;  // load the result register

    logic [2:0] state_reg, state_next;

    // configuration and control state
    logic [ID_W-1:0]  target_reg, target_next;
    logic [ID_W-1:0]  creator_reg, creator_next;
    logic             dirty_reg, dirty_next;        // order may not match the target
    logic [CNT_W-1:0] count_reg, count_next;
    logic             sort_mode_reg, sort_mode_next;
    logic             present_reg, present_next;
    logic             found_reg, found_next;

    // working registers
    entry_t           cand_reg, cand_next;          // candidate of the insert
    entry_t           hold_reg, hold_next;          // entry being placed
    logic [IDX_W-1:0] i_reg, i_next;                // outer index of the re-sort
    logic [IDX_W-1:0] j_reg, j_next;                // target slot of the walk
    logic [IDX_W-1:0] scan_reg, scan_next;

    // result register
    logic              m_valid_reg, m_valid_next;
    logic              m_found_reg, m_found_next;
    logic [ID_W-1:0]   m_node_reg, m_node_next;
    logic [IP_W-1:0]   m_addr_reg, m_addr_next;
    logic [PORT_W-1:0] m_port_reg, m_port_next;
    logic              m_pending_reg, m_pending_next;
    logic [COUNT_OUT_W-1:0] m_count_reg, m_count_next;

    // entry memory ports
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    entry_t           mem_wr_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    entry_t           mem_rd_data;

    // queried marks
    logic             qm_clr;
    logic             qm_hit;
    logic [IDX_W-1:0] qm_idx;
    logic             qm_pending;

    logic             place_done;
    logic [ID_W-1:0]  dist_rd, dist_hold, dist_cand;

    xcs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LIST_SIZE),
        .AW    (IDX_W)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // every memory write is mirrored into the mark flops
    xcs_qmark #(
        .LIST_SIZE (LIST_SIZE),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_qmark (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clr_all   (qm_clr),
        .wr_en     (mem_wr_en),
        .wr_idx    (mem_wr_addr),
        .wr_val    (mem_wr_data.queried),
        .count     (count_reg),
        .first_hit (qm_hit),
        .first_idx (qm_idx),
        .pending   (qm_pending)
    );

    assign s_ready = (state_reg == ST_IDLE);

    assign dist_rd   = mem_rd_data.node ^ target_reg;
    assign dist_hold = hold_reg.node ^ target_reg;
    assign dist_cand = cand_reg.node ^ target_reg;

    always_comb begin
        state_next     = state_reg;
        target_next    = target_reg;
        creator_next   = creator_reg;
        dirty_next     = dirty_reg;
        count_next     = count_reg;
        sort_mode_next = sort_mode_reg;
        present_next   = present_reg;
        found_next     = found_reg;
        cand_next      = cand_reg;
        hold_next      = hold_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        scan_next      = scan_reg;

        m_valid_next   = m_valid_reg && !m_ready;
        m_found_next   = m_found_reg;
        m_node_next    = m_node_reg;
        m_addr_next    = m_addr_reg;
        m_port_next    = m_port_reg;
        m_pending_next = m_pending_reg;
        m_count_next   = m_count_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = j_reg;
        mem_wr_data = hold_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        qm_clr      = 1'b0;
        place_done  = 1'b0;

        // the user must write configuration only while idle; the block does not enforce it
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_TARGET: begin
                    target_next = cfg_wr_data;
                    dirty_next  = 1'b1;
                end
                CFG_CREATOR: begin
                    creator_next = cfg_wr_data;
                end
                default: begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    found_next = 1'b0;
                    case (s_action)
                        ACT_INSERT: begin
                            cand_next.node    = s_node_id;
                            cand_next.address = s_address;
                            cand_next.port    = s_port;
                            cand_next.queried = (s_node_id == creator_reg);
                            if (dirty_reg && (count_reg > CNT_W'(1))) begin
                                // target changed: stable re-sort of the held entries first
                                sort_mode_next = 1'b1;
                                i_next         = IDX_W'(1);
                                mem_rd_en      = 1'b1;
                                mem_rd_addr    = IDX_W'(1);
                                state_next     = ST_SORT_LOAD;
                            end else begin
                                state_next = ST_DECIDE;
                            end
                        end
                        ACT_TAKE: begin
                            if (qm_hit) begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = qm_idx;
                                j_next      = qm_idx;
                                found_next  = 1'b1;
                                state_next  = ST_TAKE_WB;
                            end else begin
                                state_next = ST_FINISH;
                            end
                        end
                        ACT_CLEAR: begin
                            count_next = '0;
                            qm_clr     = 1'b1;
                            dirty_next = 1'b0;
                            state_next = ST_FINISH;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_SORT_LOAD: begin
                hold_next   = mem_rd_data;
                j_next      = i_reg;
                mem_rd_en   = 1'b1;
                mem_rd_addr = i_reg - IDX_W'(1);
                state_next  = ST_WALK;
            end

            ST_DECIDE: begin
                sort_mode_next = 1'b0;
                dirty_next     = 1'b0;
                hold_next      = cand_reg;
                if (count_reg < CNT_W'(LIST_SIZE)) begin
                    // room left: candidate enters at the end and walks down
                    count_next = count_reg + CNT_W'(1);
                    j_next     = IDX_W'(count_reg);
                    if (count_reg == '0) begin
                        state_next = ST_PLACE;
                    end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = IDX_W'(count_reg - CNT_W'(1));
                        state_next  = ST_WALK;
                    end
                end else begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = '0;
                    scan_next    = '0;
                    present_next = 1'b0;
                    state_next   = ST_SCAN;
                end
            end

            ST_SCAN: begin
                if (scan_reg == IDX_W'(LIST_SIZE - 1)) begin
                    // read data is the farthest entry
                    if (!present_reg && (dist_cand < dist_rd)) begin
                        j_next = IDX_W'(LIST_SIZE - 1);
                        if (LIST_SIZE == 1) begin
                            state_next = ST_PLACE;
                        end else begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = IDX_W'(PENULT);
                            state_next  = ST_WALK;
                        end
                    end else begin
                        state_next = ST_FINISH;
                    end
                end else begin
                    present_next = present_reg || (mem_rd_data.node == cand_reg.node);
                    scan_next    = scan_reg + IDX_W'(1);
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = scan_reg + IDX_W'(1);
                end
            end

            ST_WALK: begin
                // read data is the entry just below slot j
                mem_wr_en = 1'b1;
                if (dist_rd > dist_hold) begin
                    mem_wr_data = mem_rd_data;
                    if (j_reg == IDX_W'(1)) begin
                        j_next     = '0;
                        state_next = ST_PLACE;
                    end else begin
                        j_next      = j_reg - IDX_W'(1);
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = j_reg - IDX_W'(2);
                    end
                end else begin
                    place_done = 1'b1;
                end
            end

            ST_PLACE: begin
                mem_wr_en  = 1'b1;
                place_done = 1'b1;
            end

            ST_TAKE_WB: begin
                mem_wr_en           = 1'b1;
                mem_wr_data         = mem_rd_data;
                mem_wr_data.queried = 1'b1;
                state_next          = ST_FINISH;
            end

            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_found_next   = found_reg;
                    m_node_next    = found_reg ? mem_rd_data.node : '0;
                    m_addr_next    = found_reg ? mem_rd_data.address : '0;
                    m_port_next    = found_reg ? mem_rd_data.port : '0;
                    m_pending_next = qm_pending;
                    m_count_next   = COUNT_OUT_W'(count_reg);
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // held entry written: next outer step of a re-sort, or done
        if (place_done) begin
            if (sort_mode_reg) begin
                if ((CNT_W'(i_reg) + CNT_W'(1)) == count_reg) begin
                    state_next = ST_DECIDE;
                end else begin
                    i_next      = i_reg + IDX_W'(1);
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = i_reg + IDX_W'(1);
                    state_next  = ST_SORT_LOAD;
                end
            end else begin
                state_next = ST_FINISH;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            target_reg    <= '0;
            creator_reg   <= '0;
            dirty_reg     <= 1'b0;
            count_reg     <= '0;
            sort_mode_reg <= 1'b0;
            present_reg   <= 1'b0;
            found_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            target_reg    <= target_next;
            creator_reg   <= creator_next;
            dirty_reg     <= dirty_next;
            count_reg     <= count_next;
            sort_mode_reg <= sort_mode_next;
            present_reg   <= present_next;
            found_reg     <= found_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        cand_reg      <= cand_next;
        hold_reg      <= hold_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        scan_reg      <= scan_next;
        m_found_reg   <= m_found_next;
        m_node_reg    <= m_node_next;
        m_addr_reg    <= m_addr_next;
        m_port_reg    <= m_port_next;
        m_pending_reg <= m_pending_next;
        m_count_reg   <= m_count_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_out_node_id = m_node_reg;
    assign m_out_address = m_addr_reg;
    assign m_out_port    = m_port_reg;
    assign m_pending     = m_pending_reg;
    assign m_count       = m_count_reg;

    // the walk never targets slot zero, it places there instead
    a_walk_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> j_reg != '0)
        else $error("walk reached slot zero");

    // a taken entry must come from a non-empty list
    a_take_held: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_TAKE_WB |-> count_reg != '0)
        else $error("take with empty list");

    // a full re-sort only runs after a target change
    a_sort_dirty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SORT_LOAD |-> dirty_reg)
        else $error("re-sort without target change");

    // inside an insert the count never drops
    a_count_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE && state_reg != ST_FINISH) |=>
            count_reg >= $past(count_reg))
        else $error("count dropped during insert");

endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking regression of xor_closest_shortlist_top
// queue-fed driver and checking monitor with a built-in shortlist predictor
// depends on xcs_pkg and xor_closest_shortlist_top
`timescale 1ns / 1ps

module tb_top;
    import xcs_pkg::*;

    localparam int LIST_SIZE = DEF_LIST_SIZE;
    // action code 3 is not used by the block, it only reports status
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;
    localparam int IDLE_PCT = 15;
    localparam int RANDOM_QUOTA = 180;  // counted items per random phase
    localparam int DRAIN_CYCLES = 60;   // beyond a full-list insert

    // one input item
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [ID_W-1:0]     node_id;
        logic [IP_W-1:0]     address;
        logic [PORT_W-1:0]   port;
    } contact_req_t;

    // one result item
    typedef struct packed {
        logic                   found;
        logic [ID_W-1:0]        node_id;
        logic [IP_W-1:0]        address;
        logic [PORT_W-1:0]      port;
        logic                   pending;
        logic [COUNT_OUT_W-1:0] count;
    } shortlist_reply_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index   = CFG_TARGET;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;

    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [ACTION_W-1:0]    s_action  = ACT_INSERT;
    logic [ID_W-1:0]        s_node_id = '0;
    logic [IP_W-1:0]        s_address = '0;
    logic [PORT_W-1:0]      s_port    = '0;

    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_found;
    logic [ID_W-1:0]        m_out_node_id;
    logic [IP_W-1:0]        m_out_address;
    logic [PORT_W-1:0]      m_out_port;
    logic                   m_pending;
    logic [COUNT_OUT_W-1:0] m_count;

    xor_closest_shortlist_top #(
        .LIST_SIZE(LIST_SIZE)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_node_id    (s_node_id),
        .s_address    (s_address),
        .s_port       (s_port),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_found      (m_found),
        .m_out_node_id(m_out_node_id),
        .m_out_address(m_out_address),
        .m_out_port   (m_out_port),
        .m_pending    (m_pending),
        .m_count      (m_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // shortlist predictor: own copy of registers and held contacts
    // ------------------------------------------------------------------
    logic [ID_W-1:0] target_reg  = '0;
    logic [ID_W-1:0] creator_reg = '0;
    entry_t          model_list [LIST_SIZE];
    int              model_count = 0;

    // coverage tallies for the closing summary
    int unsigned n_inserts, n_full_inserts, n_creator, n_takes, n_returned;
    int unsigned n_clears, n_unused, n_checked;

    // stable insertion sort on xor distance to the target
    function automatic void resort_by_distance();
        entry_t moving;
        int     j;
        for (int i = 1; i < model_count; i++) begin
            moving = model_list[i];
            j = i;
            while (j > 0 && ((model_list[j-1].node ^ target_reg) >
                             (moving.node ^ target_reg))) begin
                model_list[j] = model_list[j-1];
                j--;
            end
            model_list[j] = moving;
        end
    endfunction

    // the own id enters already queried
    function automatic void place_contact(int slot, contact_req_t req);
        model_list[slot].node    = req.node_id;
        model_list[slot].address = req.address;
        model_list[slot].port    = req.port;
        model_list[slot].queried = (req.node_id == creator_reg);
        if (req.node_id == creator_reg) n_creator++;
    endfunction

    function automatic void wipe_shortlist();
        for (int i = 0; i < LIST_SIZE; i++) begin
            model_list[i] = '0;
            model_list[i].queried = 1'b1;
        end
        model_count = 0;
    endfunction

    function automatic shortlist_reply_t shortlist_step(contact_req_t req);
        shortlist_reply_t reply;
        bit               held;
        reply = '0;
        case (req.action)
            ACT_INSERT: begin
                n_inserts++;
                if (model_count < LIST_SIZE) begin
                    // room left: append without a duplicate check
                    place_contact(model_count, req);
                    model_count++;
                    resort_by_distance();
                end else begin
                    // full: re-sort first, a held id or one not closer than the last is dropped
                    n_full_inserts++;
                    resort_by_distance();
                    held = 1'b0;
                    for (int i = 0; i < LIST_SIZE; i++) begin
                        if (model_list[i].node == req.node_id) held = 1'b1;
                    end
                    if (!held && ((req.node_id ^ target_reg) <
                                  (model_list[LIST_SIZE-1].node ^ target_reg))) begin
                        place_contact(LIST_SIZE - 1, req);
                        resort_by_distance();
                    end
                end
            end
            ACT_TAKE: begin
                n_takes++;
                for (int i = 0; i < model_count; i++) begin
                    if (!model_list[i].queried && !reply.found) begin
                        reply.found   = 1'b1;
                        reply.node_id = model_list[i].node;
                        reply.address = model_list[i].address;
                        reply.port    = model_list[i].port;
                        model_list[i].queried = 1'b1;
                    end
                end
                if (reply.found) n_returned++;
            end
            ACT_CLEAR: begin
                n_clears++;
                wipe_shortlist();
            end
            default: begin
                n_unused++;
            end
        endcase
        for (int i = 0; i < model_count; i++) begin
            if (!model_list[i].queried) reply.pending = 1'b1;
        end
        reply.count = model_count[COUNT_OUT_W-1:0];
        return reply;
    endfunction

    // ------------------------------------------------------------------
    // stimulus store and generators
    // ------------------------------------------------------------------
    contact_req_t     pending_reqs[$];
    shortlist_reply_t expected_replies[$];
    logic [ID_W-1:0]  recent_ids[$];
    int unsigned      planned_count = 0;
    int               send_idle_pct = IDLE_PCT;
    int               recv_idle_pct = IDLE_PCT;
    int unsigned      mismatch_count = 0;

    function automatic void push_req(logic [ACTION_W-1:0] act, logic [ID_W-1:0] node,
                                     logic [IP_W-1:0] addr, logic [PORT_W-1:0] prt);
        pending_reqs.push_back(contact_req_t'{act, node, addr, prt});
        if (act != ACT_UNUSED) planned_count++;
        if (act == ACT_INSERT) begin
            recent_ids.push_back(node);
            if (recent_ids.size() > 32) void'(recent_ids.pop_front());
        end
    endfunction

    // candidate ids: repeats, the own id, near the target, anywhere
    function automatic logic [ID_W-1:0] pick_node_id();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 20 && recent_ids.size() != 0)
            return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        else if (sel < 28)
            return creator_reg;
        else if (sel < 60)
            return target_reg ^ ID_W'($urandom_range(0, 255));
        else
            return $urandom();
    endfunction

    function automatic void push_candidate();
        push_req(ACT_INSERT, pick_node_id(), $urandom(), PORT_W'($urandom()));
    endfunction

    // one lookup: maybe clear, a run of inserts with takes between, then a
    // burst of takes; a few broken runs and noise items mixed in
    function automatic void queue_lookup_round();
        int n_ins;
        if ($urandom_range(0, 3) != 0)
            push_req(ACT_CLEAR, $urandom(), $urandom(), PORT_W'($urandom()));
        n_ins = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 30) : $urandom_range(3, 20);
        for (int k = 0; k < n_ins; k++) begin
            push_candidate();
            if ($urandom_range(0, 99) < 30)
                push_req(ACT_TAKE, $urandom(), $urandom(), PORT_W'($urandom()));
            if ($urandom_range(0, 99) < 4)
                push_req(ACT_UNUSED, $urandom(), $urandom(), PORT_W'($urandom()));
            if ($urandom_range(0, 99) < 2)
                push_req(ACT_CLEAR, $urandom(), $urandom(), PORT_W'($urandom()));
            if ($urandom_range(0, 99) < 3)
                push_req(ACTION_W'($urandom_range(0, 3)), $urandom(), $urandom(),
                         PORT_W'($urandom()));
        end
        repeat ($urandom_range(0, 8))
            push_req(ACT_TAKE, $urandom(), $urandom(), PORT_W'($urandom()));
    endfunction

    function automatic void queue_random_phase(int unsigned quota);
        int unsigned start;
        start = planned_count;
        while (planned_count - start < quota) queue_lookup_round();
    endfunction

    // directed part, target 0 and own id 0x30
    function automatic void queue_directed();
        // take-next and an unused code on an empty list
        push_req(ACT_TAKE, '0, '0, '0);
        push_req(ACT_UNUSED, '1, '1, '1);
        // extremes, then a tie on node 0 that must keep its order
        push_req(ACT_INSERT, '1, '1, '1);
        push_req(ACT_INSERT, '0, '0, '0);
        push_req(ACT_INSERT, '0, 32'hA5A5_A5A5, 16'h5A5A);
        // fill up; 0x30 is the own id and enters queried
        for (int k = 1; k <= 13; k++)
            push_req(ACT_INSERT, ID_W'(k << 4), 32'hC0A8_0000 | k, PORT_W'(1000 + k));
        // full list: held id dropped, closer one replaces, farther one dropped
        push_req(ACT_INSERT, 32'h0000_0020, 32'h0A00_0001, 16'h0050);
        push_req(ACT_INSERT, 32'hFFFF_FFFE, 32'h0A00_0002, 16'h0051);
        push_req(ACT_INSERT, 32'hFFFF_FFFF, 32'h0A00_0003, 16'h0052);
        push_req(ACT_TAKE, '0, '0, '0);
        push_req(ACT_TAKE, '0, '0, '0);
        push_req(ACT_CLEAR, '0, '0, '0);
        push_req(ACT_TAKE, '0, '0, '0);
    endfunction

    // ------------------------------------------------------------------
    // driver: presents queued items, predicts each one as it is accepted
    // ------------------------------------------------------------------
    contact_req_t next_req;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_replies.push_back(
                    shortlist_step(contact_req_t'{s_action, s_node_id, s_address, s_port}));
            end
            // free to change the payload only when nothing is held up
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_req  = pending_reqs.pop_front();
                    s_valid   <= 1'b1;
                    s_action  <= next_req.action;
                    s_node_id <= next_req.node_id;
                    s_address <= next_req.address;
                    s_port    <= next_req.port;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random back-pressure, in-order check of every result item
    // ------------------------------------------------------------------
    shortlist_reply_t got_reply, want_reply;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got_reply = shortlist_reply_t'{m_found, m_out_node_id, m_out_address,
                                               m_out_port, m_pending, m_count};
                if (expected_replies.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: result item with nothing expected: %p", $realtime,
                                 got_reply);
                end else begin
                    want_reply = expected_replies.pop_front();
                    n_checked++;
                    if (got_reply.found   !== want_reply.found   ||
                        got_reply.node_id !== want_reply.node_id ||
                        got_reply.address !== want_reply.address ||
                        got_reply.port    !== want_reply.port    ||
                        got_reply.pending !== want_reply.pending ||
                        got_reply.count   !== want_reply.count) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("%0t: result %0d mismatch", $realtime, n_checked);
                            $display("  expected found=%b node=%h addr=%h port=%h pend=%b cnt=%0d",
                                     want_reply.found, want_reply.node_id, want_reply.address,
                                     want_reply.port, want_reply.pending, want_reply.count);
                            $display("  actual   found=%b node=%h addr=%h port=%h pend=%b cnt=%0d",
                                     got_reply.found, got_reply.node_id, got_reply.address,
                                     got_reply.port, got_reply.pending, got_reply.count);
                        end
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------

    // block idle: nothing queued, nothing presented, nothing outstanding
    task automatic wait_for_drain();
        while (pending_reqs.size() != 0 || s_valid || expected_replies.size() != 0)
            @(posedge aclk);
    endtask

    // writes both registers back to back, predictor follows at once
    task automatic program_registers(logic [ID_W-1:0] target, logic [ID_W-1:0] creator);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_TARGET;
        cfg_wr_data <= target;
        @(posedge aclk);
        cfg_index   <= CFG_CREATOR;
        cfg_wr_data <= creator;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        target_reg  = target;
        creator_reg = creator;
    endtask

    initial begin
        wipe_shortlist();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed checks on a small known list
        program_registers('0, 32'h0000_0030);
        queue_directed();
        wait_for_drain();

        // all-ones registers, with a mid-phase pause of the sender
        program_registers('1, '1);
        queue_random_phase(RANDOM_QUOTA / 2);
        wait_for_drain();
        queue_random_phase(RANDOM_QUOTA / 2);
        wait_for_drain();

        // target moved while contacts are held: old order until the next insert
        program_registers($urandom(), creator_reg);
        push_req(ACT_TAKE, '0, '0, '0);
        push_req(ACT_TAKE, '0, '0, '0);
        push_candidate();
        push_req(ACT_TAKE, '0, '0, '0);
        push_req(ACT_TAKE, '0, '0, '0);
        wait_for_drain();

        // back-to-back stretch, neither side idles
        send_idle_pct = 0;
        recv_idle_pct = 0;
        program_registers($urandom(), $urandom());
        queue_random_phase(RANDOM_QUOTA);
        wait_for_drain();
        send_idle_pct = IDLE_PCT;
        recv_idle_pct = IDLE_PCT;

        program_registers('0, '1);
        queue_random_phase(RANDOM_QUOTA);
        wait_for_drain();

        program_registers('1, '0);
        queue_random_phase(RANDOM_QUOTA);
        wait_for_drain();

        program_registers($urandom(), $urandom());
        queue_random_phase(RANDOM_QUOTA);
        wait_for_drain();

        // let any stray result item show up
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d inserts (%0d into a full list, %0d as own id), %0d take-next",
                 n_inserts, n_full_inserts, n_creator, n_takes);
        $display("%0d entries returned, %0d clears, %0d unused codes, %0d results checked",
                 n_returned, n_clears, n_unused, n_checked);
        if (mismatch_count == 0 && expected_replies.size() == 0) begin
            $display("xor_closest_shortlist_top regression: pass");
        end else begin
            $display("xor_closest_shortlist_top regression: fail");
        end
        $finish;
    end

    // hard stop, well beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("xor_closest_shortlist_top regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/xcs_pkg.sv
sv/xcs_ram.sv
sv/xcs_qmark.sv
sv/xor_closest_shortlist_top.sv
tb/sv/tb_top.sv
